@@ design/pmd_pkg.sv @@
`default_nettype none

package pmd_pkg;

   localparam int unsigned HeaderBytes = 4;
   localparam int unsigned PosBits     = $clog2(HeaderBytes);

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_DROP  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_BODY   = 3'b010,
      PH_PAD    = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] destination;
      logic [7:0] command;
      logic [7:0] body_length;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       end_of_message;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/pmd_req_if.sv @@
`default_nettype none

interface pmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       buffer_end;

   modport source (output valid, output in_byte, output buffer_end, input ready);
   modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

@@ design/pmd_rsp_if.sv @@
`default_nettype none

interface pmd_rsp_if;
   import pmd_pkg::*;

   logic       valid;
   logic       ready;
   kind_type   kind;
   logic [7:0] destination;
   logic [7:0] command;
   logic [7:0] body_length;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic       end_of_message;

   modport source (
      output valid, output kind, output destination, output command,
      output body_length, output data_byte, output byte_index,
      output end_of_message, input ready
   );
   modport sink (
      input valid, input kind, input destination, input command,
      input body_length, input data_byte, input byte_index,
      input end_of_message, output ready
   );
endinterface

`default_nettype wire

@@ design/padded_message_deframer.sv @@
// a request's result is registered in the output register, or in skid if rsp stalls
// throughput: one byte per cycle while req is ready (phase and position update)
// a two-entry result buffer (output register plus skid register) keeps req ready
// while one result waits; req stalls only when both entries are full
// synchronous active-high reset returns to the header phase, clears position,
// held header fields and both result entries
`default_nettype none

module padded_message_deframer (
   input  wire logic clock,
   input  wire logic reset,
   pmd_req_if.sink   req_ch,
   pmd_rsp_if.source rsp_ch
);
   import pmd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] dest_ff, dest_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] cmd_ff, cmd_in;

   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic         accept;
   logic         pop;
   logic         has_result;
   rsp_type      result;
   logic         last;
   logic         final_byte;
   logic [1:0]   pad;
   logic [PosBits-1:0] hpos;

   assign last   = req_ch.buffer_end;
   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = out_valid_ff && rsp_ch.ready;
   assign final_byte = ({1'b0, count_ff} + 9'd1) >= {1'b0, len_ff};
   assign pad    = 2'd0 - len_ff[1:0];
   assign hpos   = count_ff[PosBits-1:0];

   // phase and header update
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      dest_in    = dest_ff;
      len_in     = len_ff;
      cmd_in     = cmd_ff;
      has_result = 1'b0;
      result.kind           = KIND_BODY;
      result.destination    = dest_ff;
      result.command        = cmd_ff;
      result.body_length    = len_ff;
      result.data_byte      = 8'd0;
      result.byte_index     = 8'd0;
      result.end_of_message = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_BODY: begin
               has_result = 1'b1;
               if (last && !final_byte) begin
                  result.kind = KIND_DROP;
               end else begin
                  result.data_byte      = req_ch.in_byte;
                  result.byte_index     = count_ff;
                  result.end_of_message = final_byte;
                  if (final_byte) begin
                     count_in = {6'd0, pad};
                     phase_in = (pad != 2'd0) ? PH_PAD : PH_HEADER;
                  end else begin
                     count_in = count_ff + 8'd1;
                  end
               end
            end
            PH_PAD: begin
               count_in = count_ff - 8'd1;
               if (count_in == 8'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               case (hpos)
                  2'd0: dest_in = req_ch.in_byte;
                  2'd1: len_in  = req_ch.in_byte;
                  2'd2: cmd_in  = req_ch.in_byte;
                  default: ;
               endcase
               if (hpos == PosBits'(HeaderBytes - 1)) begin
                  if (len_ff == 8'd0) begin
                     has_result            = 1'b1;
                     result.kind           = KIND_EMPTY;
                     result.end_of_message = 1'b1;
                     phase_in              = PH_HEADER;
                     count_in              = 8'd0;
                  end else if (last) begin
                     has_result  = 1'b1;
                     result.kind = KIND_DROP;
                  end else begin
                     phase_in = PH_BODY;
                     count_in = 8'd0;
                  end
               end else begin
                  phase_in = PH_HEADER;
                  count_in = {6'd0, hpos} + 8'd1;
               end
            end
         endcase
         if (last) begin
            phase_in = PH_HEADER;
            count_in = 8'd0;
            dest_in  = 8'd0;
            len_in   = 8'd0;
            cmd_in   = 8'd0;
         end
      end
   end

   // two-entry result buffer
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && has_result) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         count_ff      <= 8'd0;
         dest_ff       <= 8'd0;
         len_ff        <= 8'd0;
         cmd_ff        <= 8'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         dest_ff       <= dest_in;
         len_ff        <= len_in;
         cmd_ff        <= cmd_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_ch.ready          = !skid_valid_ff;
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_ff.kind;
   assign rsp_ch.destination    = out_ff.destination;
   assign rsp_ch.command        = out_ff.command;
   assign rsp_ch.body_length    = out_ff.body_length;
   assign rsp_ch.data_byte      = out_ff.data_byte;
   assign rsp_ch.byte_index     = out_ff.byte_index;
   assign rsp_ch.end_of_message = out_ff.end_of_message;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (phase_ff == PH_HEADER && count_ff == 8'd0 && len_ff == 8'd0))
      else $error("state not cleared after final byte");

   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (count_ff < 8'(HeaderBytes)))
      else $error("header position out of range");

   a_pad_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAD) |-> (count_ff != 8'd0 && count_ff < 8'(HeaderBytes)))
      else $error("padding count out of range");

   a_body_index: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == KIND_BODY && !out_ff.end_of_message)
         |-> (({1'b0, out_ff.byte_index} + 9'd1) < {1'b0, out_ff.body_length}))
      else $error("body byte not marked last at end of body");

endmodule

`default_nettype wire
